// ===== src/gno_pkg.sv =====
// shared types, widths and codes for the gradient noise octave sum block
`timescale 1ns / 1ps
package gno_pkg;

    localparam int GNO_TABLE_SIZE = 256;

    localparam int COORD_W = 32;
    localparam int GRAD_W  = 16;
    localparam int VAL_W   = 20;
    localparam int SUM_W   = 52;
    localparam int WGT_W   = 45;
    localparam int WLO_W   = 23;
    localparam int ACC_W   = 34;
    localparam int S_W     = 17;
    localparam int MA_W    = 33;
    localparam int MB_W    = 24;
    localparam int MP_W    = MA_W + MB_W;

    typedef enum logic [1:0] {
        KIND_PERM  = 2'd0,
        KIND_GRAD3 = 2'd1,
        KIND_GRAD2 = 2'd2,
        KIND_EVAL  = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_DIM   = 2'd0;
    localparam logic [1:0] CFG_OCT   = 2'd1;
    localparam logic [1:0] CFG_FALL  = 2'd2;
    localparam logic [1:0] CFG_FSTEP = 2'd3;

    typedef struct packed {
        t_kind                      kind;
        logic [7:0]                 table_index;
        logic [7:0]                 perm_value;
        logic signed [GRAD_W-1:0]   grad_x;
        logic signed [GRAD_W-1:0]   grad_y;
        logic signed [GRAD_W-1:0]   grad_z;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] noise_value;
        logic                    saturated;
    } t_out_item;

endpackage

// ===== src/gno_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module gno_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/gno_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module gno_mul (
    input  logic                        i_clk,
    input  logic signed [gno_pkg::MA_W-1:0] i_a,
    input  logic signed [gno_pkg::MB_W-1:0] i_b,
    output logic signed [gno_pkg::MP_W-1:0] o_p
);
    import gno_pkg::*;

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a) * MP_W'(i_b);
    end

    assign o_p = r_p;
endmodule

// ===== src/gradient_noise_octave_sum.sv =====
// gradient noise octave sum: an evaluate of N octaves steps one shared multiplier through
// the s-curves, dots, lerps and scaling of each octave
// load transactions do not make the block busy; a new transaction is taken only while busy is low
// the result strobe is high for one cycle and cannot be held off by the receiver
// synchronous active-low reset clears control and sets config to defaults; tables are undefined until loaded
`timescale 1ns / 1ps
module gradient_noise_octave_sum #(
    parameter int TABLE_SIZE = gno_pkg::GNO_TABLE_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  gno_pkg::t_in_item  i_item,
    output logic               o_valid,
    output gno_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import gno_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);

    typedef enum logic [16:0] {
        S_IDLE = 17'd1,
        S_SQ   = 17'd2,
        S_SK   = 17'd4,
        S_SS   = 17'd8,
        S_PERM = 17'd16,
        S_DADR = 17'd32,
        S_DMUL = 17'd64,
        S_DACC = 17'd128,
        S_LMUL = 17'd256,
        S_LACC = 17'd512,
        S_T0   = 17'd1024,
        S_T1   = 17'd2048,
        S_T2   = 17'd4096,
        S_T3   = 17'd8192,
        S_T4   = 17'd16384,
        S_CU   = 17'd32768,
        S_FIN  = 17'd65536
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic        r_dim, n_dim;
    logic [3:0]  r_octc, n_octc;
    logic [15:0] r_fall, n_fall;
    logic [15:0] r_fstep, n_fstep;

    // datapath state
    logic signed [COORD_W-1:0] r_c [3];
    logic signed [COORD_W-1:0] n_c [3];
    logic [S_W-1:0]            r_s [3];
    logic [S_W-1:0]            n_s [3];
    logic [7:0]                r_h [4];
    logic [7:0]                n_h [4];
    logic signed [VAL_W-1:0]   r_stk [4];
    logic signed [VAL_W-1:0]   n_stk [4];
    logic [7:0]                r_i, n_i, r_j, n_j;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [MP_W-1:0]    r_lo, n_lo;
    logic [WGT_W-1:0]          r_w, n_w;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic                      r_three, n_three;
    logic [3:0]                r_oct, n_oct;
    logic [2:0]                r_n, n_n;
    logic [1:0]                r_ax, n_ax;
    logic [1:0]                r_lv, n_lv;
    logic [2:0]                r_pc, n_pc;
    logic                      r_valid, n_valid;
    t_out_item                 r_res, n_res;

    // memories and multiplier
    logic [AW-1:0]          b0 [3];
    logic [AW-1:0]          b1 [3];
    logic [AW-1:0]          perm_raddr, grad_raddr, wr_addr;
    logic [7:0]             perm_rd;
    logic [47:0]            g3_rd;
    logic [31:0]            g2_rd;
    logic                   accept;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    // combinational helpers
    logic [15:0]             fr_ax;
    logic [17:0]             sk_k;
    logic [MP_W-1:0]         s_rnd;
    logic signed [GRAD_W-1:0] g_comp;
    logic signed [S_W-1:0]   r_axis;
    logic signed [ACC_W-1:0] acc_sum, acc_rnd;
    logic signed [17:0]      dot18;
    logic signed [VAL_W-1:0] dot_v;
    logic signed [20:0]      l_diff;
    logic signed [MP_W-1:0]  l_rnd;
    logic signed [40:0]      l_q;
    logic signed [VAL_W-1:0] l_res;
    logic signed [63:0]      t_prod, t_term;
    logic [63:0]             w_sum;
    logic signed [MP_W-1:0]  c_rnd;
    logic [7:0]              h_sel;
    logic [3:0]              n_bits;
    logic [1:0]              lv_nx, lv_max, ax_last;
    logic [2:0]              n_last;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b0[k] = r_c[k][16 +: AW];
            b1[k] = b0[k] + AW'(1);
        end
    end

    assign accept  = i_start && !o_busy;
    assign wr_addr = AW'(i_item.table_index);

    always_comb begin
        case (r_pc)
            3'd0:    perm_raddr = b0[0];
            3'd1:    perm_raddr = b1[0];
            3'd2:    perm_raddr = AW'(r_i) + b0[1];
            3'd3:    perm_raddr = AW'(r_j) + b0[1];
            3'd4:    perm_raddr = AW'(r_i) + b1[1];
            default: perm_raddr = AW'(r_j) + b1[1];
        endcase
    end

    assign h_sel      = r_h[r_n[1:0]];
    assign grad_raddr = r_three ? (AW'(h_sel) + (r_n[2] ? b1[2] : b0[2])) : AW'(h_sel);

    gno_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm (
        .i_clk   (i_clk),
        .i_we    (accept && (i_item.kind == KIND_PERM)),
        .i_waddr (wr_addr),
        .i_wdata (i_item.perm_value),
        .i_re    (r_state == S_PERM),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rd)
    );

    gno_ram #(.WIDTH(48), .DEPTH(TABLE_SIZE)) u_grad3 (
        .i_clk   (i_clk),
        .i_we    (accept && (i_item.kind == KIND_GRAD3)),
        .i_waddr (wr_addr),
        .i_wdata ({i_item.grad_z, i_item.grad_y, i_item.grad_x}),
        .i_re    (r_state == S_DADR),
        .i_raddr (grad_raddr),
        .o_rdata (g3_rd)
    );

    gno_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_grad2 (
        .i_clk   (i_clk),
        .i_we    (accept && (i_item.kind == KIND_GRAD2)),
        .i_waddr (wr_addr),
        .i_wdata ({i_item.grad_y, i_item.grad_x}),
        .i_re    (r_state == S_DADR),
        .i_raddr (grad_raddr),
        .o_rdata (g2_rd)
    );

    gno_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // arithmetic around the shared multiplier
    assign fr_ax   = r_c[r_ax][15:0];
    assign sk_k    = 18'd196608 - {1'b0, fr_ax, 1'b0};
    assign s_rnd   = $unsigned(mul_p) + (MP_W'(1) << 31);
    assign g_comp  = r_three ? g3_rd[{r_ax, 4'b0} +: 16] : g2_rd[{r_ax[0], 4'b0} +: 16];
    // offset from the corner: r0 or r0 - 1 share the low bits
    assign r_axis  = {r_n[r_ax], fr_ax};
    assign acc_sum = r_acc + ACC_W'(mul_p);
    assign acc_rnd = acc_sum + ACC_W'(32768);
    assign dot18   = acc_rnd[33:16];
    assign dot_v   = VAL_W'(dot18);
    assign l_diff  = 21'(r_stk[0]) - 21'(r_stk[1]);
    assign l_rnd   = mul_p + MP_W'(32768);
    assign l_q     = l_rnd[MP_W-1:16];
    assign l_res   = r_stk[1] + VAL_W'(l_q);
    assign t_prod  = 64'(r_lo) + (64'(mul_p) <<< WLO_W);
    assign t_term  = (t_prod + 64'sd8192) >>> 14;
    assign w_sum   = 64'($unsigned(r_lo)) + (64'($unsigned(mul_p)) << WLO_W) + 64'd8192;
    assign c_rnd   = mul_p + MP_W'(2048);
    assign n_bits  = {1'b0, r_n};
    assign lv_nx   = r_lv + 2'd1;
    assign lv_max  = r_three ? 2'd2 : 2'd1;
    assign ax_last = r_three ? 2'd2 : 2'd1;
    assign n_last  = r_three ? 3'd7 : 3'd3;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = MA_W'({1'b0, fr_ax});
                mul_b = MB_W'({1'b0, fr_ax});
            end
            S_SK: begin
                mul_a = {1'b0, mul_p[31:0]};
                mul_b = MB_W'({1'b0, sk_k});
            end
            S_DMUL: begin
                mul_a = MA_W'(r_axis);
                mul_b = MB_W'(g_comp);
            end
            S_LMUL: begin
                mul_a = MA_W'({1'b0, r_s[r_lv]});
                mul_b = MB_W'(l_diff);
            end
            S_T0: begin
                mul_a = MA_W'(r_stk[0]);
                mul_b = MB_W'({1'b0, r_w[WLO_W-1:0]});
            end
            S_T1: begin
                mul_a = MA_W'(r_stk[0]);
                mul_b = MB_W'({1'b0, r_w[WGT_W-1:WLO_W]});
            end
            S_T2: begin
                mul_a = MA_W'({1'b0, r_w[WLO_W-1:0]});
                mul_b = MB_W'({1'b0, r_fall});
            end
            S_T3: begin
                mul_a = MA_W'({1'b0, r_w[WGT_W-1:WLO_W]});
                mul_b = MB_W'({1'b0, r_fall});
            end
            S_T4: begin
                mul_a = MA_W'(r_c[0]);
                mul_b = MB_W'({1'b0, r_fstep});
            end
            S_CU: begin
                mul_a = MA_W'(r_c[(r_ax == 2'd0) ? 1 : 2]);
                mul_b = MB_W'({1'b0, r_fstep});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_dim   = r_dim;
        n_octc  = r_octc;
        n_fall  = r_fall;
        n_fstep = r_fstep;
        n_c     = r_c;
        n_s     = r_s;
        n_h     = r_h;
        n_stk   = r_stk;
        n_i     = r_i;
        n_j     = r_j;
        n_acc   = r_acc;
        n_lo    = r_lo;
        n_w     = r_w;
        n_sum   = r_sum;
        n_three = r_three;
        n_oct   = r_oct;
        n_n     = r_n;
        n_ax    = r_ax;
        n_lv    = r_lv;
        n_pc    = r_pc;
        n_valid = 1'b0;
        n_res   = r_res;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM:   n_dim   = i_cfg_data[0];
                CFG_OCT:   n_octc  = i_cfg_data[3:0];
                CFG_FALL:  n_fall  = i_cfg_data;
                CFG_FSTEP: n_fstep = i_cfg_data;
                default:   n_dim   = r_dim;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_item.kind == KIND_EVAL)) begin
                    n_c[0]  = i_item.coord_x;
                    n_c[1]  = i_item.coord_y;
                    n_c[2]  = r_dim ? i_item.coord_z : '0;
                    n_three = r_dim;
                    n_oct   = r_octc;
                    n_w     = WGT_W'(16384);
                    n_sum   = '0;
                    n_ax    = 2'd0;
                    n_state = (r_octc == 4'd0) ? S_FIN : S_SQ;
                end
            end
            S_SQ: n_state = S_SK;
            S_SK: n_state = S_SS;
            S_SS: begin
                n_s[r_ax] = s_rnd[48:32];
                if (r_ax == 2'd2) begin
                    n_pc    = 3'd0;
                    n_state = S_PERM;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_PERM: begin
                case (r_pc)
                    3'd1:    n_i    = perm_rd;
                    3'd2:    n_j    = perm_rd;
                    3'd3:    n_h[0] = perm_rd;
                    3'd4:    n_h[1] = perm_rd;
                    3'd5:    n_h[2] = perm_rd;
                    3'd6:    n_h[3] = perm_rd;
                    default: n_i    = r_i;
                endcase
                if (r_pc == 3'd6) begin
                    n_n     = 3'd0;
                    n_state = S_DADR;
                end else begin
                    n_pc = r_pc + 3'd1;
                end
            end
            S_DADR: begin
                n_acc   = '0;
                n_ax    = 2'd0;
                n_state = S_DMUL;
            end
            S_DMUL: n_state = S_DACC;
            S_DACC: begin
                n_acc = acc_sum;
                if (r_ax != ax_last) begin
                    n_ax    = r_ax + 2'd1;
                    n_state = S_DMUL;
                end else begin
                    n_stk[0] = dot_v;
                    n_stk[1] = r_stk[0];
                    n_stk[2] = r_stk[1];
                    n_stk[3] = r_stk[2];
                    // odd corner closes a pair, so blend it
                    if (r_n[0]) begin
                        n_lv    = 2'd0;
                        n_state = S_LMUL;
                    end else begin
                        n_n     = r_n + 3'd1;
                        n_state = S_DADR;
                    end
                end
            end
            S_LMUL: n_state = S_LACC;
            S_LACC: begin
                n_stk[0] = l_res;
                n_stk[1] = r_stk[2];
                n_stk[2] = r_stk[3];
                if ((lv_nx <= lv_max) && n_bits[lv_nx]) begin
                    n_lv    = lv_nx;
                    n_state = S_LMUL;
                end else if (r_n == n_last) begin
                    n_state = S_T0;
                end else begin
                    n_n     = r_n + 3'd1;
                    n_state = S_DADR;
                end
            end
            S_T0: n_state = S_T1;
            S_T1: begin
                n_lo    = mul_p;
                n_state = S_T2;
            end
            S_T2: begin
                n_sum   = r_sum + SUM_W'(t_term);
                n_state = S_T3;
            end
            S_T3: begin
                n_lo    = mul_p;
                n_state = S_T4;
            end
            S_T4: begin
                n_w     = w_sum[14 +: WGT_W];
                n_ax    = 2'd0;
                n_state = S_CU;
            end
            S_CU: begin
                n_c[r_ax] = c_rnd[43:12];
                if (r_ax == 2'd2) begin
                    n_ax = 2'd0;
                    if (r_oct == 4'd1) begin
                        n_state = S_FIN;
                    end else begin
                        n_oct   = r_oct - 4'd1;
                        n_state = S_SQ;
                    end
                end else begin
                    n_ax = r_ax + 2'd1;
                end
            end
            S_FIN: begin
                n_valid = 1'b1;
                if (r_sum > SUM_W'(524287)) begin
                    n_res.noise_value = 20'sd524287;
                    n_res.saturated   = 1'b1;
                end else if (r_sum < -SUM_W'(524288)) begin
                    n_res.noise_value = -20'sd524288;
                    n_res.saturated   = 1'b1;
                end else begin
                    n_res.noise_value = VAL_W'(r_sum);
                    n_res.saturated   = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_dim   <= 1'b1;
            r_octc  <= 4'd1;
            r_fall  <= 16'd8192;
            r_fstep <= 16'd8192;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dim   <= n_dim;
            r_octc  <= n_octc;
            r_fall  <= n_fall;
            r_fstep <= n_fstep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_s     <= n_s;
        r_h     <= n_h;
        r_stk   <= n_stk;
        r_i     <= n_i;
        r_j     <= n_j;
        r_acc   <= n_acc;
        r_lo    <= n_lo;
        r_w     <= n_w;
        r_sum   <= n_sum;
        r_three <= n_three;
        r_oct   <= n_oct;
        r_n     <= n_n;
        r_ax    <= n_ax;
        r_lv    <= n_lv;
        r_pc    <= n_pc;
        r_res   <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.kind == KIND_EVAL)) |=> o_busy)
        else $error("evaluate transaction did not start the sequencer");

    a_corner_range_2d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DADR) && !r_three) |-> !r_n[2])
        else $error("corner count beyond four in 2d mode");
`endif
endmodule
